@@ hdl/fct_pkg.sv @@
package fct_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int COUNT_BITS  = 16;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int STEP_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

  // Operation codes carried by the kind field.
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } flow_key_t;

  typedef struct packed {
    flow_key_t             key;
    logic [COUNT_BITS-1:0] cnt;
    logic [15:0]           fref;
  } entry_t;

  typedef struct packed {
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic                 shift_en;
  } cell_ctrl_t;

endpackage

@@ hdl/flow_count_table_unit.sv @@
// Exact-match five-tuple flow table with saturating packet counters. The
// entries sit in a row of cells that rotates toward cell 0; the head cell is
// compared and updated and its entry re-enters at the tail. A lookup makes
// one full turn of the row to bring every entry past the head comparator
// and back to its place. An insert writes its cell directly. A flush walks
// the used entries through the head, one per cycle while the result side
// does not stall; it delivers one result per single-packet flow, the last
// one marked, or one empty result when there is none. An unused kind code
// is taken and gives no result. The input stalls until the operation in
// hand has delivered its final result.
module flow_count_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [15:0] in_flow_ref,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [15:0] out_hit_count,
  output logic [15:0] out_hit_ref,
  output logic        out_overflow,
  output logic        out_single_valid,
  output logic [15:0] out_single_ref,
  output logic        out_last
);

  localparam int D = fct_pkg::TABLE_DEPTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FLUSH,
    ST_FINISH
  } state_t;

  state_t                       state_r, state_nxt;
  logic [fct_pkg::STEP_W-1:0]   used_r, used_nxt;
  logic [fct_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  logic [15:0]                  pend_ref_r, pend_ref_nxt;
  fct_pkg::flow_key_t           key_r, key_nxt;

  logic                         res_hit_r, res_hit_nxt;
  logic [15:0]                  res_cnt_r, res_cnt_nxt;
  logic [15:0]                  res_ref_r, res_ref_nxt;
  logic                         res_ovf_r, res_ovf_nxt;
  logic                         res_sv_r, res_sv_nxt;
  logic [15:0]                  res_sref_r, res_sref_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic [15:0]                  out_cnt_r, out_cnt_nxt;
  logic [15:0]                  out_ref_r, out_ref_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic                         out_sv_r, out_sv_nxt;
  logic [15:0]                  out_sref_r, out_sref_nxt;
  logic                         out_last_r, out_last_nxt;

  fct_pkg::entry_t              ent [D];
  fct_pkg::entry_t              head;
  fct_pkg::entry_t              tail_in;
  fct_pkg::entry_t              wr_ent;
  fct_pkg::cell_ctrl_t          cell_ctrl;
  fct_pkg::flow_key_t           in_key;
  logic [fct_pkg::COUNT_BITS-1:0] cnt_inc;
  logic                         out_free;
  logic                         head_live;
  logic                         head_single;

  assign in_key = '{src_addr: in_src_addr, dst_addr: in_dst_addr, protocol: in_protocol,
                    src_port: in_src_port, dst_port: in_dst_port};

  assign head        = ent[0];
  assign head_live   = (step_r < used_r);
  assign head_single = (head.cnt == fct_pkg::COUNT_ONE);
  assign cnt_inc     = (head.cnt == fct_pkg::COUNT_MAX) ? head.cnt
                                                        : head.cnt + fct_pkg::COUNT_ONE;
  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != ST_IDLE);

  assign wr_ent = '{key: in_key, cnt: fct_pkg::COUNT_ONE, fref: in_flow_ref};

  for (genvar i = 0; i < D; i++) begin : g_cell
    if (i == D - 1) begin : g_tail
      fct_cell u_cell (
        .clk      (clk),
        .cell_idx (fct_pkg::IDX_W'(i)),
        .ctrl     (cell_ctrl),
        .wr_ent   (wr_ent),
        .shift_in (tail_in),
        .ent      (ent[i])
      );
    end else begin : g_body
      fct_cell u_cell (
        .clk      (clk),
        .cell_idx (fct_pkg::IDX_W'(i)),
        .ctrl     (cell_ctrl),
        .wr_ent   (wr_ent),
        .shift_in (ent[i+1]),
        .ent      (ent[i])
      );
    end
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    step_nxt       = step_r;
    pend_valid_nxt = pend_valid_r;
    pend_ref_nxt   = pend_ref_r;
    key_nxt        = key_r;
    res_hit_nxt    = res_hit_r;
    res_cnt_nxt    = res_cnt_r;
    res_ref_nxt    = res_ref_r;
    res_ovf_nxt    = res_ovf_r;
    res_sv_nxt     = res_sv_r;
    res_sref_nxt   = res_sref_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_hit_nxt    = out_hit_r;
    out_cnt_nxt    = out_cnt_r;
    out_ref_nxt    = out_ref_r;
    out_ovf_nxt    = out_ovf_r;
    out_sv_nxt     = out_sv_r;
    out_sref_nxt   = out_sref_r;
    out_last_nxt   = out_last_r;

    cell_ctrl.wr_en    = 1'b0;
    cell_ctrl.wr_idx   = used_r[fct_pkg::IDX_W-1:0];
    cell_ctrl.shift_en = 1'b0;
    tail_in            = head;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt      = in_key;
          res_hit_nxt  = 1'b0;
          res_cnt_nxt  = '0;
          res_ref_nxt  = '0;
          res_ovf_nxt  = 1'b0;
          res_sv_nxt   = 1'b0;
          res_sref_nxt = '0;
          step_nxt     = '0;
          case (in_kind)
            fct_pkg::KIND_LOOKUP: begin
              state_nxt = ST_LOOKUP;
            end
            fct_pkg::KIND_INSERT: begin
              if (used_r == fct_pkg::STEP_W'(D)) begin
                res_ovf_nxt = 1'b1;
              end else begin
                cell_ctrl.wr_en = 1'b1;
                used_nxt        = used_r + fct_pkg::STEP_W'(1);
              end
              state_nxt = ST_FINISH;
            end
            fct_pkg::KIND_FLUSH: begin
              pend_valid_nxt = 1'b0;
              pend_ref_nxt   = '0;
              state_nxt      = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end

      ST_LOOKUP: begin
        // One full turn of the row; only the first live match is updated.
        cell_ctrl.shift_en = 1'b1;
        if (head_live && !res_hit_r && (head.key == key_r)) begin
          tail_in.cnt = cnt_inc;
          res_hit_nxt = 1'b1;
          res_cnt_nxt = 16'(cnt_inc);
          res_ref_nxt = head.fref;
        end
        step_nxt = step_r + fct_pkg::STEP_W'(1);
        if (step_r == fct_pkg::STEP_W'(D - 1)) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FLUSH: begin
        // A single-packet reference is held back until the next one is found, so
        // that the final one can carry the last mark.
        if (!head_live) begin
          res_sv_nxt   = pend_valid_r;
          res_sref_nxt = pend_valid_r ? pend_ref_r : 16'd0;
          used_nxt     = '0;
          state_nxt    = ST_FINISH;
        end else if (!(head_single && pend_valid_r && !out_free)) begin
          cell_ctrl.shift_en = 1'b1;
          step_nxt           = step_r + fct_pkg::STEP_W'(1);
          if (head_single) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_hit_nxt   = 1'b0;
              out_cnt_nxt   = '0;
              out_ref_nxt   = '0;
              out_ovf_nxt   = 1'b0;
              out_sv_nxt    = 1'b1;
              out_sref_nxt  = pend_ref_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_ref_nxt   = head.fref;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_cnt_nxt   = res_cnt_r;
          out_ref_nxt   = res_ref_r;
          out_ovf_nxt   = res_ovf_r;
          out_sv_nxt    = res_sv_r;
          out_sref_nxt  = res_sref_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      used_r       <= '0;
      step_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      step_r       <= step_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_ref_r <= pend_ref_nxt;
    key_r      <= key_nxt;
    res_hit_r  <= res_hit_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_ref_r  <= res_ref_nxt;
    res_ovf_r  <= res_ovf_nxt;
    res_sv_r   <= res_sv_nxt;
    res_sref_r <= res_sref_nxt;
    out_hit_r  <= out_hit_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_ref_r  <= out_ref_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_sv_r   <= out_sv_nxt;
    out_sref_r <= out_sref_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_hit_count    = out_cnt_r;
  assign out_hit_ref      = out_ref_r;
  assign out_overflow     = out_ovf_r;
  assign out_single_valid = out_sv_r;
  assign out_single_ref   = out_sref_r;
  assign out_last         = out_last_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= fct_pkg::STEP_W'(D))
    else $error("entry count beyond table depth");

  a_lookup_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOKUP |-> step_r < fct_pkg::STEP_W'(D))
    else $error("lookup rotation ran past one full turn");

  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_FLUSH || state_r == ST_FINISH))
    else $error("non-final result outside a flush");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && state_nxt == ST_FINISH) |=> used_r == '0)
    else $error("flush left entries in the table");

endmodule

@@ hdl/fct_cell.sv @@
module fct_cell (
  input  logic                    clk,
  input  logic [fct_pkg::IDX_W-1:0] cell_idx,
  input  fct_pkg::cell_ctrl_t     ctrl,
  input  fct_pkg::entry_t         wr_ent,
  input  fct_pkg::entry_t         shift_in,
  output fct_pkg::entry_t         ent
);

  fct_pkg::entry_t ent_r;
  fct_pkg::entry_t ent_nxt;
  logic            sel_wr;

  // A direct write lands only in the cell whose position matches the pointer;
  // otherwise the cell takes its neighbor's entry while the row rotates.
  assign sel_wr = ctrl.wr_en && (ctrl.wr_idx == cell_idx);

  always_comb begin
    ent_nxt = ent_r;
    if (sel_wr) begin
      ent_nxt = wr_ent;
    end else if (ctrl.shift_en) begin
      ent_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

@@ dv/flow_table_checker.sv @@
module flow_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [7:0]  in_protocol,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [15:0] in_flow_ref,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_hit,
  input  logic [15:0] out_hit_count,
  input  logic [15:0] out_hit_ref,
  input  logic        out_overflow,
  input  logic        out_single_valid,
  input  logic [15:0] out_single_ref,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          results,
  output int          hits,
  output int          misses,
  output int          drops,
  output int          singles,
  output int          flushes
);

  typedef struct packed {
    logic        hit;
    logic [15:0] count;
    logic [15:0] fref;
    logic        overflow;
    logic        single_valid;
    logic [15:0] single_ref;
    logic        last;
  } flow_result_t;

  fct_pkg::flow_key_t             key_mem   [fct_pkg::TABLE_DEPTH];
  logic [fct_pkg::COUNT_BITS-1:0] count_mem [fct_pkg::TABLE_DEPTH];
  logic [15:0]                    ref_mem   [fct_pkg::TABLE_DEPTH];
  int                             entries;
  flow_result_t                   expected_results[$];
  fct_pkg::flow_key_t             in_key;

  assign in_key = {in_src_addr, in_dst_addr, in_protocol, in_src_port, in_dst_port};

  initial begin
    entries    = 0;
    fail_count = 0;
    pending    = 0;
    results    = 0;
    hits       = 0;
    misses     = 0;
    drops      = 0;
    singles    = 0;
    flushes    = 0;
  end

  // Updates the table copy for one accepted operation and queues its results.
  task automatic apply_flow_op(input logic [1:0] kind, input fct_pkg::flow_key_t key,
                               input logic [15:0] fref);
    flow_result_t r;
    bit           found;
    int           last_single;
    r           = '0;
    found       = 1'b0;
    last_single = -1;
    case (kind)
      fct_pkg::KIND_LOOKUP: begin
        for (int i = 0; i < fct_pkg::TABLE_DEPTH; i++) begin
          if (!found && i < entries && key_mem[i] == key) begin
            found = 1'b1;
            if (count_mem[i] != fct_pkg::COUNT_MAX) count_mem[i] = count_mem[i] + 1'b1;
            r.hit   = 1'b1;
            r.count = 16'(count_mem[i]);
            r.fref  = ref_mem[i];
          end
        end
        if (found) hits++;
        else misses++;
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      fct_pkg::KIND_INSERT: begin
        if (entries >= fct_pkg::TABLE_DEPTH) begin
          r.overflow = 1'b1;
          drops++;
        end else begin
          key_mem[entries]   = key;
          count_mem[entries] = fct_pkg::COUNT_ONE;
          ref_mem[entries]   = fref;
          entries++;
        end
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      fct_pkg::KIND_FLUSH: begin
        for (int i = 0; i < entries; i++) begin
          if (count_mem[i] == fct_pkg::COUNT_ONE) last_single = i;
        end
        for (int i = 0; i < entries; i++) begin
          if (count_mem[i] == fct_pkg::COUNT_ONE) begin
            r              = '0;
            r.single_valid = 1'b1;
            r.single_ref   = ref_mem[i];
            r.last         = (i == last_single);
            expected_results.push_back(r);
            singles++;
          end
        end
        if (last_single < 0) begin
          r.last = 1'b1;
          expected_results.push_back(r);
        end
        entries = 0;
        flushes++;
      end
      default: ;  // The unused code leaves the table alone and gives nothing back.
    endcase
  endtask

  task automatic report_bad(input bit had_expected, input flow_result_t exp_r,
                            input flow_result_t act);
    fail_count++;
    if (fail_count <= 10) begin
      if (!had_expected) begin
        $display("%0t: unexpected result hit=%0b count=%0d ref=%0d ovf=%0b",
                 $realtime, act.hit, act.count, act.fref, act.overflow,
                 " single=%0b/%0d last=%0b", act.single_valid, act.single_ref, act.last);
      end else begin
        $display("%0t: mismatch: expected hit=%0b count=%0d ref=%0d ovf=%0b",
                 $realtime, exp_r.hit, exp_r.count, exp_r.fref, exp_r.overflow,
                 " single=%0b/%0d last=%0b", exp_r.single_valid, exp_r.single_ref,
                 exp_r.last);
        $display("                  got hit=%0b count=%0d ref=%0d ovf=%0b",
                 act.hit, act.count, act.fref, act.overflow,
                 " single=%0b/%0d last=%0b", act.single_valid, act.single_ref, act.last);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    flow_result_t act;
    flow_result_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) apply_flow_op(in_kind, in_key, in_flow_ref);
      if (out_valid && !out_stall) begin
        act = {out_hit, out_hit_count, out_hit_ref, out_overflow, out_single_valid,
               out_single_ref, out_last};
        results++;
        if (expected_results.size() == 0) begin
          report_bad(1'b0, '0, act);
        end else begin
          exp_r = expected_results.pop_front();
          if (act !== exp_r) report_bad(1'b1, exp_r, act);
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ dv/tb.sv @@
module tb;

  // The block takes this code and does nothing with it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int         HOLD_CYCLES = 400;
  localparam int         OP_TARGET   = 260;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind     = fct_pkg::KIND_LOOKUP;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_dst_addr = '0;
  logic [7:0]  in_protocol = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_dst_port = '0;
  logic [15:0] in_flow_ref = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic        out_hit;
  logic [15:0] out_hit_count;
  logic [15:0] out_hit_ref;
  logic        out_overflow;
  logic        out_single_valid;
  logic [15:0] out_single_ref;
  logic        out_last;

  int fail_count, pending, results, hits, misses, drops, singles, flushes;
  int          ops_sent    = 0;
  bit          calm        = 1'b0;
  bit          hold_out    = 1'b0;
  bit          pressure_go = 1'b0;
  int unsigned stall_left  = 0;

  flow_count_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_src_addr      (in_src_addr),
    .in_dst_addr      (in_dst_addr),
    .in_protocol      (in_protocol),
    .in_src_port      (in_src_port),
    .in_dst_port      (in_dst_port),
    .in_flow_ref      (in_flow_ref),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_hit_count    (out_hit_count),
    .out_hit_ref      (out_hit_ref),
    .out_overflow     (out_overflow),
    .out_single_valid (out_single_valid),
    .out_single_ref   (out_single_ref),
    .out_last         (out_last)
  );

  flow_table_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_src_addr      (in_src_addr),
    .in_dst_addr      (in_dst_addr),
    .in_protocol      (in_protocol),
    .in_src_port      (in_src_port),
    .in_dst_port      (in_dst_port),
    .in_flow_ref      (in_flow_ref),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_hit_count    (out_hit_count),
    .out_hit_ref      (out_hit_ref),
    .out_overflow     (out_overflow),
    .out_single_valid (out_single_valid),
    .out_single_ref   (out_single_ref),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending),
    .results          (results),
    .hits             (hits),
    .misses           (misses),
    .drops            (drops),
    .singles          (singles),
    .flushes          (flushes)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: random stall bursts, a forced long hold-off, none at the end.
  always @(posedge clk) begin
    if (hold_out) begin
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Holds the result side off long enough for the table to back up its input.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic fct_pkg::flow_key_t random_key();
    fct_pkg::flow_key_t k;
    k.src_addr = $urandom;
    k.dst_addr = $urandom;
    k.protocol = 8'($urandom_range(0, 255));
    k.src_port = 16'($urandom_range(0, 16'hFFFF));
    k.dst_port = 16'($urandom_range(0, 16'hFFFF));
    return k;
  endfunction

  // Flips one bit of one key field so the key just misses.
  function automatic fct_pkg::flow_key_t near_miss(input fct_pkg::flow_key_t k,
                                                   input int field);
    case (field)
      0:       k.src_addr = k.src_addr ^ (32'd1 << $urandom_range(0, 31));
      1:       k.dst_addr = k.dst_addr ^ (32'd1 << $urandom_range(0, 31));
      2:       k.protocol = k.protocol ^ (8'd1 << $urandom_range(0, 7));
      3:       k.src_port = k.src_port ^ (16'd1 << $urandom_range(0, 15));
      default: k.dst_port = k.dst_port ^ (16'd1 << $urandom_range(0, 15));
    endcase
    return k;
  endfunction

  task automatic send_op(input logic [1:0] kind, input fct_pkg::flow_key_t key,
                         input logic [15:0] fref);
    if (ops_sent > OP_TARGET - 45) calm <= 1'b1;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_src_addr <= key.src_addr;
    in_dst_addr <= key.dst_addr;
    in_protocol <= key.protocol;
    in_src_port <= key.src_port;
    in_dst_port <= key.dst_port;
    in_flow_ref <= fref;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind != KIND_UNUSED) ops_sent++;
  endtask

  initial begin : stimulus
    fct_pkg::flow_key_t zk, ok, ka, kb, kc, k;
    fct_pkg::flow_key_t keys[$];
    int                 n_ins, n_look, pick, ep;
    zk = '0;
    ok = '1;
    ka = random_key();
    kb = random_key();
    kc = random_key();
    ep = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_op(fct_pkg::KIND_LOOKUP, zk, 16'h0000);
    send_op(fct_pkg::KIND_FLUSH, ok, 16'hFFFF);
    send_op(KIND_UNUSED, ok, 16'hFFFF);
    send_op(fct_pkg::KIND_INSERT, zk, 16'h0000);
    send_op(fct_pkg::KIND_INSERT, ok, 16'hFFFF);
    send_op(fct_pkg::KIND_LOOKUP, ok, 16'h0000);
    send_op(fct_pkg::KIND_LOOKUP, zk, 16'hFFFF);
    // The same key twice: lookups must land on the first copy.
    send_op(fct_pkg::KIND_INSERT, ka, 16'h1234);
    send_op(fct_pkg::KIND_INSERT, ka, 16'h5678);
    send_op(fct_pkg::KIND_LOOKUP, ka, 16'h0000);
    send_op(fct_pkg::KIND_LOOKUP, ka, 16'h0000);
    for (int f = 0; f < 5; f++) send_op(fct_pkg::KIND_LOOKUP, near_miss(ka, f), 16'h0000);
    send_op(fct_pkg::KIND_INSERT, kb, 16'($urandom));
    send_op(fct_pkg::KIND_INSERT, kc, 16'($urandom));
    send_op(fct_pkg::KIND_LOOKUP, kc, 16'h0000);
    send_op(fct_pkg::KIND_FLUSH, zk, 16'h0000);
    send_op(fct_pkg::KIND_FLUSH, zk, 16'h0000);
    send_op(fct_pkg::KIND_LOOKUP, ka, 16'h0000);

    // Episodes of inserts and lookups closed by a flush. The first one fills
    // the table past its end with no lookups, so the flush reports every entry.
    while (ops_sent < OP_TARGET) begin
      if (ep == 1) pressure_go = 1'b1;
      if (ep == 0) n_ins = fct_pkg::TABLE_DEPTH + 2;
      else if ($urandom_range(0, 5) == 0) n_ins = $urandom_range(20, fct_pkg::TABLE_DEPTH + 4);
      else n_ins = $urandom_range(1, 12);
      n_look = (ep == 0) ? 0 : $urandom_range(0, 16);
      keys.delete();
      while (n_ins + n_look > 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          send_op(KIND_UNUSED, random_key(), 16'($urandom));
        end else if (n_ins > 0 && (n_look == 0 || pick < 50)) begin
          if (keys.size() > 0 && $urandom_range(0, 9) == 0)
            k = keys[$urandom_range(0, keys.size() - 1)];
          else
            k = random_key();
          keys.push_back(k);
          send_op(fct_pkg::KIND_INSERT, k, 16'($urandom));
          n_ins--;
        end else begin
          if (keys.size() > 0 && pick < 80)
            k = keys[$urandom_range(0, keys.size() - 1)];
          else if (keys.size() > 0 && pick < 92)
            k = near_miss(keys[$urandom_range(0, keys.size() - 1)], $urandom_range(0, 4));
          else
            k = random_key();
          send_op(fct_pkg::KIND_LOOKUP, k, 16'($urandom));
          n_look--;
        end
      end
      send_op(fct_pkg::KIND_FLUSH, random_key(), 16'($urandom));
      ep++;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (fct_pkg::TABLE_DEPTH + 8) @(posedge clk);
    $display("Ran %0d table operations in %0d episodes, checked %0d results:", ops_sent, ep,
             results);
    $display("%0d hits, %0d misses, %0d dropped inserts, %0d flushes with %0d one-packet flows.",
             hits, misses, drops, flushes, singles);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
